@@ src/gsrp_pkg.sv @@
// Shared types, constants and helpers for the GPIO serial clock port.
// Depends on nothing; every other file takes its names from here.
`default_nettype none
package gsrp_pkg;

	// Field widths of one bus access and of one result
	localparam int FUNC_W    = 1;
	localparam int OFFSET_W  = 3;
	localparam int WDATA_W   = 16;
	localparam int YEAR_W    = 7;
	localparam int MONTH_W   = 4;
	localparam int DAY_W     = 5;
	localparam int WEEKDAY_W = 3;
	localparam int HOUR_W    = 5;
	localparam int MINUTE_W  = 6;
	localparam int SECOND_W  = 6;
	localparam int RDATA_W   = 8;

	// Bus function codes
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// Register offsets (low byte of each halfword register)
	localparam logic [OFFSET_W-1:0] OFF_DATA      = 3'd0;
	localparam logic [OFFSET_W-1:0] OFF_DIRECTION = 3'd2;
	localparam logic [OFFSET_W-1:0] OFF_CONTROL   = 3'd4;

	// Pin bit positions in the data and direction registers
	localparam int PIN_SCK = 0;
	localparam int PIN_SIO = 1;
	localparam int PIN_CS  = 2;

	// Control register bit that makes data and direction readable
	localparam int CTRL_READ_EN = 0;

	// Serial command byte
	localparam logic [3:0] CMD_MAGIC    = 4'h6;
	localparam int         CMD_READ_BIT = 7;
	localparam logic [2:0] CMD_RESET    = 3'd0;
	localparam logic [2:0] CMD_DATETIME = 3'd2;
	localparam logic [2:0] CMD_STATUS   = 3'd4;
	localparam logic [2:0] CMD_TIME     = 3'd6;

	// Status register bit selecting 24-hour form
	localparam int STATUS_24H = 6;

	// Number of parameter bytes for each command register
	localparam logic [2:0] BYTE_COUNTS [8] = '{3'd0, 3'd0, 3'd7, 3'd0, 3'd1, 3'd0, 3'd3, 3'd0};

	localparam int DATETIME_BYTES = 7;
	localparam int TIME_BYTES     = 3;
	localparam int TIME_START     = 4;

	typedef logic [7:0] byte_t;

	// Two-digit BCD of a 7-bit value; tens wrap modulo ten.
	// v / 10 is taken as (v * 205) >> 11, exact for all 7-bit values.
	function automatic byte_t to_bcd(input logic [6:0] v);
		logic [17:0] prod;
		logic [3:0]  tens;
		logic [6:0]  rem;
		prod = 18'(v) * 18'd205;
		tens = prod[14:11];
		rem  = v - 7'(tens) * 7'd10;
		if (tens >= 4'd10) begin
			tens = tens - 4'd10;
		end
		return {tens, rem[3:0]};
	endfunction

endpackage
`default_nettype wire

@@ src/gsrp_req_if.sv @@
// Request channel of the port: one bus access plus the current time.
// Depends on gsrp_pkg for the field widths.
`default_nettype none
interface gsrp_req_if;
	logic                              valid;
	logic                              ready;
	logic [gsrp_pkg::FUNC_W-1:0]       func;
	logic [gsrp_pkg::OFFSET_W-1:0]     offset;
	logic [gsrp_pkg::WDATA_W-1:0]      wdata;
	logic [gsrp_pkg::YEAR_W-1:0]       year;
	logic [gsrp_pkg::MONTH_W-1:0]      month;
	logic [gsrp_pkg::DAY_W-1:0]        day;
	logic [gsrp_pkg::WEEKDAY_W-1:0]    weekday;
	logic [gsrp_pkg::HOUR_W-1:0]       hour;
	logic [gsrp_pkg::MINUTE_W-1:0]     minute;
	logic [gsrp_pkg::SECOND_W-1:0]     second;

	modport source (
		output valid, func, offset, wdata, year, month, day, weekday, hour, minute, second,
		input  ready
	);
	modport sink (
		input  valid, func, offset, wdata, year, month, day, weekday, hour, minute, second,
		output ready
	);
endinterface
`default_nettype wire

@@ src/gsrp_rsp_if.sv @@
// Response channel of the port: hit flag and read byte.
// Depends on gsrp_pkg for the field widths.
`default_nettype none
interface gsrp_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           handled;
	logic [gsrp_pkg::RDATA_W-1:0]   rdata;

	modport source (
		output valid, handled, rdata,
		input  ready
	);
	modport sink (
		input  valid, handled, rdata,
		output ready
	);
endinterface
`default_nettype wire

@@ src/gpio_serial_rtc_port.sv @@
// GPIO port with data, direction and control registers driving a three-wire serial clock.
// Depends on gsrp_pkg, gsrp_req_if and gsrp_rsp_if.
//
// Each request transfer is one bus access and yields exactly one response transfer, which
// appears in the result register in the cycle after acceptance. Requests are taken every
// cycle as long as the result register is empty or is being drained in the same cycle,
// so the sustained rate is one access per clock; the single result register sets both
// the latency and the point where back-pressure from the response side stops the request
// side. Writes to the data register that raise SCK while CS is high advance the serial
// clock by one bit; a completed time or date-time read command loads the parameter buffer
// with BCD time taken from the same request. The parameter buffer powers up undefined
// and needs no clearing pass.
`default_nettype none
module gpio_serial_rtc_port #(
	parameter int MAX_BYTES = 7
) (
	input  wire          clk,
	input  wire          arst_n,
	gsrp_req_if.sink     req,
	gsrp_rsp_if.source   rsp
);

	localparam int IDX_W = $clog2(MAX_BYTES);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_COMMAND = 2'd1;
	localparam logic [1:0] PH_IN      = 2'd2;
	localparam logic [1:0] PH_OUT     = 2'd3;

	// Architectural state
	logic [15:0]     pin_data_q, pin_direction_q, port_control_q;
	logic            chip_sio_out_q;
	logic [7:0]      clock_status_q;
	logic [1:0]      phase_q;
	logic [3:0]      bit_count_q;
	logic [7:0]      command_shift_q;
	logic [2:0]      command_index_q;
	logic            command_is_read_q;
	gsrp_pkg::byte_t byte_buffer_q [MAX_BYTES];
	logic [2:0]      byte_position_q, byte_total_q;

	// Next state
	logic [15:0]     pin_data_d, pin_direction_d, port_control_d;
	logic            chip_sio_out_d;
	logic [7:0]      clock_status_d;
	logic [1:0]      phase_d;
	logic [3:0]      bit_count_d;
	logic [7:0]      command_shift_d;
	logic [2:0]      command_index_d;
	logic            command_is_read_d;
	gsrp_pkg::byte_t byte_buffer_d [MAX_BYTES];
	logic [2:0]      byte_position_d, byte_total_d;

	// Result register
	logic            rsp_valid_q;
	logic            handled_q;
	logic [7:0]      rdata_q;

	logic            accept;
	logic            hit;
	logic [7:0]      rd_byte;

	// Time bytes in BCD, in serial order
	gsrp_pkg::byte_t time_bcd [gsrp_pkg::DATETIME_BYTES];
	logic [4:0]      hour_sel;

	assign req.ready   = !rsp_valid_q || rsp.ready;
	assign accept      = req.valid && req.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.handled = handled_q;
	assign rsp.rdata   = rdata_q;

	always_comb begin
		hour_sel = req.hour;
		if (!clock_status_q[gsrp_pkg::STATUS_24H]) begin
			if (req.hour >= 5'd24) begin
				hour_sel = req.hour - 5'd24;
			end else if (req.hour >= 5'd12) begin
				hour_sel = req.hour - 5'd12;
			end
		end
		time_bcd[0] = gsrp_pkg::to_bcd(req.year);
		time_bcd[1] = gsrp_pkg::to_bcd({3'd0, req.month});
		time_bcd[2] = gsrp_pkg::to_bcd({2'd0, req.day});
		time_bcd[3] = gsrp_pkg::to_bcd({4'd0, req.weekday});
		time_bcd[4] = gsrp_pkg::to_bcd({2'd0, hour_sel});
		time_bcd[5] = gsrp_pkg::to_bcd({1'b0, req.minute});
		time_bcd[6] = gsrp_pkg::to_bcd({1'b0, req.second});
	end

	// Read path works on the state before this access.
	always_comb begin
		logic [15:0] reg_val;
		reg_val = '0;
		hit     = 1'b0;
		if (req.func == gsrp_pkg::FUNC_READ) begin
			if (req.offset[2:1] == gsrp_pkg::OFF_CONTROL[2:1]) begin
				hit     = 1'b1;
				reg_val = port_control_q;
			end else if (port_control_q[gsrp_pkg::CTRL_READ_EN] && !req.offset[2]) begin
				hit = 1'b1;
				if (req.offset[2:1] == gsrp_pkg::OFF_DATA[2:1]) begin
					reg_val = pin_data_q;
					if (!pin_direction_q[gsrp_pkg::PIN_SIO]) begin
						reg_val[gsrp_pkg::PIN_SIO] = chip_sio_out_q;
					end
				end else begin
					reg_val = pin_direction_q;
				end
			end
		end
		rd_byte = req.offset[0] ? reg_val[15:8] : reg_val[7:0];
	end

	// Write path and serial clock engine
	always_comb begin
		logic       old_cs, new_cs, sio;
		logic [1:0] phase_mid;
		logic [3:0] bit_mid;
		logic [7:0] shift_mid;
		logic [2:0] b;
		logic [3:0] bc;
		logic [2:0] idx;
		logic [2:0] total;
		logic       pos_ok;
		logic [IDX_W-1:0] pos_idx;

		pin_data_d        = pin_data_q;
		pin_direction_d   = pin_direction_q;
		port_control_d    = port_control_q;
		chip_sio_out_d    = chip_sio_out_q;
		clock_status_d    = clock_status_q;
		phase_d           = phase_q;
		bit_count_d       = bit_count_q;
		command_shift_d   = command_shift_q;
		command_index_d   = command_index_q;
		command_is_read_d = command_is_read_q;
		byte_buffer_d     = byte_buffer_q;
		byte_position_d   = byte_position_q;
		byte_total_d      = byte_total_q;

		old_cs    = pin_data_q[gsrp_pkg::PIN_CS];
		new_cs    = req.wdata[gsrp_pkg::PIN_CS];
		sio       = req.wdata[gsrp_pkg::PIN_SIO];
		phase_mid = phase_q;
		bit_mid   = bit_count_q;
		shift_mid = command_shift_q;
		b         = '0;
		bc        = '0;
		idx       = '0;
		total     = '0;
		pos_ok    = ({1'b0, byte_position_q} < 4'(MAX_BYTES));
		pos_idx   = byte_position_q[IDX_W-1:0];

		if (req.func == gsrp_pkg::FUNC_WRITE) begin
			case (req.offset)
				gsrp_pkg::OFF_CONTROL: begin
					port_control_d = req.wdata;
				end
				gsrp_pkg::OFF_DIRECTION: begin
					pin_direction_d = req.wdata;
				end
				gsrp_pkg::OFF_DATA: begin
					pin_data_d = req.wdata;
					if (new_cs && !old_cs) begin
						phase_mid = PH_COMMAND;
						bit_mid   = '0;
						shift_mid = '0;
					end else if (!new_cs && old_cs) begin
						phase_mid = PH_IDLE;
					end
					phase_d         = phase_mid;
					bit_count_d     = bit_mid;
					command_shift_d = shift_mid;

					if (new_cs && req.wdata[gsrp_pkg::PIN_SCK] &&
					    !pin_data_q[gsrp_pkg::PIN_SCK]) begin
						b  = bit_mid[2:0];
						bc = {1'b0, b} + 4'd1;
						case (phase_mid)
							PH_COMMAND: begin
								shift_mid       = shift_mid | (8'(sio) << b);
								command_shift_d = shift_mid;
								bit_count_d     = bc;
								if (bc == 4'd8) begin
									// Command byte complete: decode and set up the buffer.
									idx               = shift_mid[6:4];
									command_index_d   = idx;
									command_is_read_d = shift_mid[gsrp_pkg::CMD_READ_BIT];
									bit_count_d       = '0;
									byte_position_d   = '0;
									if (shift_mid[3:0] != gsrp_pkg::CMD_MAGIC) begin
										phase_d = PH_IDLE;
									end else begin
										total        = gsrp_pkg::BYTE_COUNTS[idx];
										byte_total_d = total;
										if (idx == gsrp_pkg::CMD_RESET) begin
											clock_status_d = '0;
											phase_d        = PH_IDLE;
										end else if (total == 3'd0) begin
											phase_d = PH_IDLE;
										end else if (shift_mid[gsrp_pkg::CMD_READ_BIT]) begin
											if (idx == gsrp_pkg::CMD_STATUS) begin
												byte_buffer_d[0] = clock_status_q;
											end else if (idx == gsrp_pkg::CMD_TIME) begin
												for (int i = 0; i < gsrp_pkg::TIME_BYTES; i++) begin
													byte_buffer_d[i] =
														time_bcd[i + gsrp_pkg::TIME_START];
												end
											end else begin
												for (int i = 0; i < gsrp_pkg::DATETIME_BYTES;
												     i++) begin
													byte_buffer_d[i] = time_bcd[i];
												end
											end
											phase_d = PH_OUT;
										end else begin
											for (int i = 0; i < MAX_BYTES; i++) begin
												if (4'(i) < {1'b0, total}) begin
													byte_buffer_d[i] = '0;
												end
											end
											phase_d = PH_IN;
										end
									end
								end
							end
							PH_IN: begin
								if (pos_ok) begin
									byte_buffer_d[pos_idx] =
										byte_buffer_q[pos_idx] | (8'(sio) << b);
								end
								bit_count_d = bc;
								if (bc == 4'd8) begin
									bit_count_d     = '0;
									byte_position_d = byte_position_q + 3'd1;
									if ({1'b0, byte_position_q} + 4'd1 >=
									    {1'b0, byte_total_q}) begin
										if (command_index_q == gsrp_pkg::CMD_STATUS) begin
											clock_status_d = byte_buffer_d[0];
										end
										phase_d = PH_IDLE;
									end
								end
							end
							PH_OUT: begin
								chip_sio_out_d = pos_ok ? byte_buffer_q[pos_idx][b] : 1'b0;
								bit_count_d    = bc;
								if (bc == 4'd8) begin
									bit_count_d     = '0;
									byte_position_d = byte_position_q + 3'd1;
									if ({1'b0, byte_position_q} + 4'd1 >=
									    {1'b0, byte_total_q}) begin
										phase_d = PH_IDLE;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_data_q        <= '0;
			pin_direction_q   <= '0;
			port_control_q    <= '0;
			chip_sio_out_q    <= 1'b0;
			clock_status_q    <= '0;
			phase_q           <= PH_IDLE;
			bit_count_q       <= '0;
			command_shift_q   <= '0;
			command_index_q   <= '0;
			command_is_read_q <= 1'b0;
			byte_position_q   <= '0;
			byte_total_q      <= '0;
		end else if (accept) begin
			pin_data_q        <= pin_data_d;
			pin_direction_q   <= pin_direction_d;
			port_control_q    <= port_control_d;
			chip_sio_out_q    <= chip_sio_out_d;
			clock_status_q    <= clock_status_d;
			phase_q           <= phase_d;
			bit_count_q       <= bit_count_d;
			command_shift_q   <= command_shift_d;
			command_index_q   <= command_index_d;
			command_is_read_q <= command_is_read_d;
			byte_position_q   <= byte_position_d;
			byte_total_q      <= byte_total_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_buffer_q <= byte_buffer_d;
		end
	end

	// Result register: loaded on each request transfer, held until the response transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.func == gsrp_pkg::FUNC_READ) begin
				handled_q <= hit;
				rdata_q   <= hit ? rd_byte : 8'd0;
			end else begin
				handled_q <= (req.offset == gsrp_pkg::OFF_DATA) ||
				             (req.offset == gsrp_pkg::OFF_DIRECTION) ||
				             (req.offset == gsrp_pkg::OFF_CONTROL);
				rdata_q   <= 8'd0;
			end
		end
	end

endmodule
`default_nettype wire

@@ dv/gsrp_checker.sv @@
// Reply checker for the GPIO serial clock port: keeps its own copy of the port registers
// and of the serial clock chip, predicts the reply to each request transfer and compares.
// Depends on gsrp_pkg and the request and reply channel interfaces.
module gsrp_checker (
	input  logic clk,
	input  logic arst_n,
	gsrp_req_if  req,
	gsrp_rsp_if  rsp,
	output int   failures,
	output int   pending
);

	localparam int BUF_DEPTH = 7;

	typedef enum logic [1:0] {
		SER_IDLE,
		SER_COMMAND,
		SER_WRITE_PARAMS,
		SER_READ_PARAMS
	} serial_phase_t;

	typedef struct packed {
		logic            handled;
		gsrp_pkg::byte_t rdata;
	} reply_t;

	// Port registers
	logic [15:0] data_reg, dir_reg, ctrl_reg;

	// Serial clock chip
	logic            chip_sio;
	gsrp_pkg::byte_t rtc_status;
	serial_phase_t   ser_phase;
	logic [3:0]      bits_done;
	gsrp_pkg::byte_t cmd_bits;
	logic [2:0]      cmd_target;
	logic            cmd_read;
	gsrp_pkg::byte_t param_bytes [BUF_DEPTH];
	logic [2:0]      param_idx, param_count;

	// Time fields of the request being predicted: year, month, day, weekday, hour, minute,
	// second, in that order
	int unsigned clock_now [7];

	reply_t expected_replies [$];
	reply_t want;
	int     mismatch_count;

	function automatic gsrp_pkg::byte_t two_digit_bcd(input int unsigned v);
		return gsrp_pkg::byte_t'((((v / 10) % 10) << 4) | (v % 10));
	endfunction

	// A full command byte has been shifted in.
	function automatic void decode_command();
		gsrp_pkg::byte_t clock_bytes [7];
		int unsigned     hr;
		int              first;
		int              i;
		cmd_target = cmd_bits[6:4];
		cmd_read   = cmd_bits[gsrp_pkg::CMD_READ_BIT];
		bits_done  = '0;
		param_idx  = '0;
		// A bad magic nibble still latches the command fields but keeps the old byte count.
		if (cmd_bits[3:0] != gsrp_pkg::CMD_MAGIC) begin
			ser_phase = SER_IDLE;
			return;
		end
		param_count = gsrp_pkg::BYTE_COUNTS[cmd_target];
		if (cmd_target == gsrp_pkg::CMD_RESET) begin
			rtc_status = '0;
			ser_phase  = SER_IDLE;
			return;
		end
		if (param_count == 0) begin
			ser_phase = SER_IDLE;
			return;
		end
		if (cmd_read) begin
			if (cmd_target == gsrp_pkg::CMD_STATUS) begin
				param_bytes[0] = rtc_status;
			end else begin
				hr = clock_now[4];
				if (!rtc_status[gsrp_pkg::STATUS_24H]) begin
					hr = hr % 12;
				end
				for (i = 0; i < 7; i++) begin
					clock_bytes[i] = two_digit_bcd(i == 4 ? hr : clock_now[i]);
				end
				first = (cmd_target == gsrp_pkg::CMD_TIME) ? gsrp_pkg::TIME_START : 0;
				for (i = 0; i < param_count && i < BUF_DEPTH && first + i < 7; i++) begin
					param_bytes[i] = clock_bytes[first + i];
				end
			end
			ser_phase = SER_READ_PARAMS;
		end else begin
			for (i = 0; i < param_count && i < BUF_DEPTH; i++) begin
				param_bytes[i] = '0;
			end
			ser_phase = SER_WRITE_PARAMS;
		end
	endfunction

	// One rising SCK edge while CS is high.
	function automatic void serial_clock(input logic sio);
		logic [2:0] b;
		int         pos;
		b   = bits_done[2:0];
		pos = param_idx;
		case (ser_phase)
			SER_COMMAND: begin
				cmd_bits  = cmd_bits | (gsrp_pkg::byte_t'(sio) << b);
				bits_done = 4'(b) + 4'd1;
				if (bits_done == 4'd8) begin
					decode_command();
				end
			end
			SER_WRITE_PARAMS: begin
				if (pos < BUF_DEPTH) begin
					param_bytes[pos] = param_bytes[pos] | (gsrp_pkg::byte_t'(sio) << b);
				end
				bits_done = 4'(b) + 4'd1;
				if (bits_done == 4'd8) begin
					bits_done = '0;
					param_idx = 3'(pos + 1);
					if (pos + 1 >= param_count) begin
						// The status byte only takes effect once it is complete.
						if (cmd_target == gsrp_pkg::CMD_STATUS) begin
							rtc_status = param_bytes[0];
						end
						ser_phase = SER_IDLE;
					end
				end
			end
			SER_READ_PARAMS: begin
				chip_sio  = (pos < BUF_DEPTH) ? param_bytes[pos][b] : 1'b0;
				bits_done = 4'(b) + 4'd1;
				if (bits_done == 4'd8) begin
					bits_done = '0;
					param_idx = 3'(pos + 1);
					if (pos + 1 >= param_count) begin
						ser_phase = SER_IDLE;
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic reply_t port_access(input logic fn, input logic [2:0] off,
			input logic [15:0] wd);
		reply_t      r;
		logic [15:0] word;
		logic [2:0]  base;
		logic        cs_was, cs_now;
		r    = '0;
		word = '0;
		base = {off[2:1], 1'b0};
		if (fn == gsrp_pkg::FUNC_READ) begin
			if (base == gsrp_pkg::OFF_CONTROL) begin
				r.handled = 1'b1;
				word      = ctrl_reg;
			end else if (ctrl_reg[gsrp_pkg::CTRL_READ_EN] && base == gsrp_pkg::OFF_DATA) begin
				r.handled = 1'b1;
				word      = data_reg;
				// With SIO set as an input the pin reflects the chip.
				if (!dir_reg[gsrp_pkg::PIN_SIO]) begin
					word[gsrp_pkg::PIN_SIO] = chip_sio;
				end
			end else if (ctrl_reg[gsrp_pkg::CTRL_READ_EN] &&
			             base == gsrp_pkg::OFF_DIRECTION) begin
				r.handled = 1'b1;
				word      = dir_reg;
			end
			r.rdata = off[0] ? word[15:8] : word[7:0];
		end else begin
			if (off == gsrp_pkg::OFF_CONTROL) begin
				ctrl_reg  = wd;
				r.handled = 1'b1;
			end else if (off == gsrp_pkg::OFF_DIRECTION) begin
				dir_reg   = wd;
				r.handled = 1'b1;
			end else if (off == gsrp_pkg::OFF_DATA) begin
				cs_was = data_reg[gsrp_pkg::PIN_CS];
				cs_now = wd[gsrp_pkg::PIN_CS];
				if (cs_now && !cs_was) begin
					ser_phase = SER_COMMAND;
					bits_done = '0;
					cmd_bits  = '0;
				end else if (!cs_now && cs_was) begin
					ser_phase = SER_IDLE;
				end
				if (cs_now && wd[gsrp_pkg::PIN_SCK] && !data_reg[gsrp_pkg::PIN_SCK]) begin
					serial_clock(wd[gsrp_pkg::PIN_SIO]);
				end
				data_reg  = wd;
				r.handled = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_reg    = '0;
			dir_reg     = '0;
			ctrl_reg    = '0;
			chip_sio    = 1'b0;
			rtc_status  = '0;
			ser_phase   = SER_IDLE;
			bits_done   = '0;
			cmd_bits    = '0;
			cmd_target  = '0;
			cmd_read    = 1'b0;
			param_idx   = '0;
			param_count = '0;
			foreach (param_bytes[i]) begin
				param_bytes[i] = '0;
			end
			expected_replies.delete();
			mismatch_count = 0;
			failures <= 0;
			pending  <= 0;
		end else begin
			// A reply never leaves in the cycle of its own request, so it is checked first.
			if (rsp.valid && rsp.ready) begin
				if (expected_replies.size() == 0) begin
					$error("reply transfer with no request outstanding");
					mismatch_count++;
				end else begin
					want = expected_replies.pop_front();
					if (rsp.handled !== want.handled) begin
						$error("handled: expected %0d, got %0d", want.handled, rsp.handled);
						mismatch_count++;
					end
					if (rsp.rdata !== want.rdata) begin
						$error("rdata: expected 0x%02h, got 0x%02h", want.rdata, rsp.rdata);
						mismatch_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				clock_now[0] = req.year;
				clock_now[1] = req.month;
				clock_now[2] = req.day;
				clock_now[3] = req.weekday;
				clock_now[4] = req.hour;
				clock_now[5] = req.minute;
				clock_now[6] = req.second;
				expected_replies.push_back(port_access(req.func, req.offset, req.wdata));
			end
			failures <= mismatch_count;
			pending  <= expected_replies.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
// Top of the GPIO serial clock port testbench: clock, reset, bus accesses and serial
// clock transactions, reply back-pressure, a stall watchdog and the final verdict.
// Depends on gsrp_pkg, the channel interfaces, gsrp_checker and gpio_serial_rtc_port.
module testbench;

	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_TOTAL = 1600;

	logic clk = 1'b0;
	logic arst_n;
	int   src_idle_pct, snk_idle_pct;
	int   accesses;
	int   bits_left;
	int   failures, pending;

	gsrp_req_if req_ch ();
	gsrp_rsp_if rsp_ch ();

	gpio_serial_rtc_port dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	gsrp_checker port_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Ends the run when no transfer happens on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Data register word with the given pins and random upper bits.
	function automatic logic [15:0] pin_word(input logic cs, input logic sio, input logic sck);
		logic [15:0] w;
		w                   = 16'($urandom);
		w[gsrp_pkg::PIN_CS]  = cs;
		w[gsrp_pkg::PIN_SIO] = sio;
		w[gsrp_pkg::PIN_SCK] = sck;
		return w;
	endfunction

	// Called at a rising edge; returns at the edge where the transfer takes place.
	task automatic bus_access(input logic fn, input logic [2:0] off, input logic [15:0] wd);
		int pick;
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pick = $urandom_range(15);
		req_ch.valid  <= 1'b1;
		req_ch.func   <= fn;
		req_ch.offset <= off;
		req_ch.wdata  <= wd;
		if (pick == 0) begin
			req_ch.year    <= 7'd0;
			req_ch.month   <= 4'd1;
			req_ch.day     <= 5'd1;
			req_ch.weekday <= 3'd0;
			req_ch.hour    <= 5'd0;
			req_ch.minute  <= 6'd0;
			req_ch.second  <= 6'd0;
		end else if (pick == 1) begin
			req_ch.year    <= 7'd99;
			req_ch.month   <= 4'd12;
			req_ch.day     <= 5'd31;
			req_ch.weekday <= 3'd6;
			req_ch.hour    <= 5'd23;
			req_ch.minute  <= 6'd59;
			req_ch.second  <= 6'd59;
		end else if (pick == 2) begin
			// Out-of-range time values are encoded digit by digit all the same.
			req_ch.year    <= 7'($urandom);
			req_ch.month   <= 4'($urandom);
			req_ch.day     <= 5'($urandom);
			req_ch.weekday <= 3'($urandom);
			req_ch.hour    <= 5'($urandom);
			req_ch.minute  <= 6'($urandom);
			req_ch.second  <= 6'($urandom);
		end else begin
			req_ch.year    <= 7'($urandom_range(99));
			req_ch.month   <= 4'($urandom_range(1, 12));
			req_ch.day     <= 5'($urandom_range(1, 31));
			req_ch.weekday <= 3'($urandom_range(6));
			req_ch.hour    <= 5'($urandom_range(23));
			req_ch.minute  <= 6'($urandom_range(59));
			req_ch.second  <= 6'($urandom_range(59));
		end
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		if (fn == gsrp_pkg::FUNC_READ || off == gsrp_pkg::OFF_DATA ||
		    off == gsrp_pkg::OFF_DIRECTION || off == gsrp_pkg::OFF_CONTROL) begin
			accesses++;
		end
	endtask

	// Clocks up to eight bits LSB first; stops early once the bit budget is spent.
	task automatic clock_byte(input gsrp_pkg::byte_t value, input logic sample);
		int i;
		for (i = 0; i < 8 && bits_left > 0; i++) begin
			bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_DATA, pin_word(1'b1, value[i], 1'b0));
			bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_DATA, pin_word(1'b1, value[i], 1'b1));
			if (sample) begin
				bus_access(gsrp_pkg::FUNC_READ, gsrp_pkg::OFF_DATA, 16'($urandom));
			end else if ($urandom_range(5) == 0) begin
				bus_access(gsrp_pkg::FUNC_READ, 3'($urandom), 16'($urandom));
			end
			bits_left--;
		end
	endtask

	// One serial clock transaction: CS rise, command byte, parameter bytes, CS fall.
	task automatic rtc_transaction();
		logic [2:0]      target;
		logic            is_read;
		gsrp_pkg::byte_t cmd;
		logic [15:0]     w;
		int              n, k, pick;
		pick = $urandom_range(11);
		if (pick < 3) begin
			target = gsrp_pkg::CMD_DATETIME;
		end else if (pick < 6) begin
			target = gsrp_pkg::CMD_STATUS;
		end else if (pick < 9) begin
			target = gsrp_pkg::CMD_TIME;
		end else if (pick == 9) begin
			target = gsrp_pkg::CMD_RESET;
		end else begin
			target = 3'($urandom);
		end
		is_read = 1'($urandom);
		cmd     = {is_read, target, gsrp_pkg::CMD_MAGIC};
		if ($urandom_range(9) == 0) begin
			cmd[3:0] = gsrp_pkg::CMD_MAGIC ^ 4'($urandom_range(1, 15));
		end
		if ($urandom_range(2) == 0) begin
			w                         = 16'($urandom);
			w[gsrp_pkg::CTRL_READ_EN] = ($urandom_range(7) != 0);
			bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_CONTROL, w);
			w                         = 16'($urandom);
			w[gsrp_pkg::PIN_SIO]      = ($urandom_range(5) == 0);
			bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_DIRECTION, w);
		end
		n = gsrp_pkg::BYTE_COUNTS[target] + ($urandom_range(7) == 0);
		bits_left = 8 * (n + 1);
		// Now and then CS drops part way through.
		if ($urandom_range(9) == 0) begin
			bits_left = $urandom_range(bits_left - 1);
		end
		bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_DATA,
			pin_word(1'b0, 1'($urandom), 1'($urandom)));
		bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_DATA, pin_word(1'b1, 1'($urandom), 1'b0));
		clock_byte(cmd, 1'b0);
		for (k = 0; k < n; k++) begin
			clock_byte(gsrp_pkg::byte_t'($urandom), is_read);
		end
		bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_DATA,
			pin_word(1'b0, 1'($urandom), 1'($urandom)));
	endtask

	initial begin
		int off, phase_no;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.func    = '0;
		req_ch.offset  = '0;
		req_ch.wdata   = '0;
		req_ch.year    = '0;
		req_ch.month   = '0;
		req_ch.day     = '0;
		req_ch.weekday = '0;
		req_ch.hour    = '0;
		req_ch.minute  = '0;
		req_ch.second  = '0;
		rsp_ch.ready   = 1'b0;
		src_idle_pct   = 26;
		snk_idle_pct   = 74;
		accesses       = 0;
		bits_left      = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Register map with read-back disabled, then enabled with SIO as an output.
		for (off = 0; off < 8; off++) begin
			bus_access(gsrp_pkg::FUNC_READ, 3'(off), 16'($urandom));
		end
		bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_CONTROL, 16'hFFFF);
		bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_DIRECTION, 16'hFFFF);
		// CS and SCK rise in one write, so the command starts with a bit already in.
		bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_DATA, 16'hFFFF);
		for (off = 0; off < 8; off++) begin
			bus_access(gsrp_pkg::FUNC_READ, 3'(off), 16'($urandom));
		end
		bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_DIRECTION, 16'h0000);
		bus_access(gsrp_pkg::FUNC_READ, gsrp_pkg::OFF_DATA, 16'h0000);
		// Odd and unmapped offsets take no write.
		for (off = 1; off < 8; off++) begin
			if (off % 2 == 1 || off == 6) begin
				bus_access(gsrp_pkg::FUNC_WRITE, 3'(off),
					(off % 4 == 1) ? 16'hFFFF : 16'h0000);
			end
		end
		bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_DATA, 16'h0000);
		bus_access(gsrp_pkg::FUNC_WRITE, gsrp_pkg::OFF_CONTROL, 16'h0000);

		for (phase_no = 0; phase_no < 3; phase_no++) begin
			if (phase_no == 0) begin
				src_idle_pct = 26;
				snk_idle_pct = 74;
			end else if (phase_no == 1) begin
				src_idle_pct = 74;
				snk_idle_pct = 26;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			while (accesses < ITEMS_TOTAL * (phase_no + 1) / 3) begin
				if ($urandom_range(4) == 0) begin
					bus_access(1'($urandom), 3'($urandom), 16'($urandom));
				end else begin
					rtc_transaction();
				end
			end
			// Hold the request side until every reply has been transferred.
			req_ch.valid <= 1'b0;
			@(posedge clk);
			while (pending != 0) begin
				@(posedge clk);
			end
		end

		repeat (4) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
